@@ sv/cpar_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cpar_pkg;

   // Fixed field widths of the item and result words.
   localparam int COORD_W   = 32;
   localparam int LEN_W     = 32;
   localparam int COUNT_W   = 16;
   localparam int PERIM_W   = 42;
   localparam int REM_W     = 43;
   localparam int RATIO_W   = 33;
   localparam int DIVREM_W  = 33;
   localparam int ITER_W    = 6;

   localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 16'd64;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   // Division lengths, counted down to zero.
   localparam logic [ITER_W-1:0] STEP_ITER_LAST  = 6'd41;
   localparam logic [ITER_W-1:0] RATIO_ITER_LAST = 6'd31;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [LEN_W-1:0]   len;
   } vtx_entry_type;

   typedef enum logic [1:0] {
      RD_CUR  = 2'd0,
      RD_NEXT = 2'd1,
      RD_ZERO = 2'd2
   } rd_sel_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic       load;
      logic       step_go;
      logic       ratio_go;
      logic       div_run;
      logic       step_done;
      logic       ratio_set;
      logic       ratio_done;
      logic       restart;
      logic       lat_v;
      logic       lat_n;
      logic       mul_en;
      axis_type   mul_axis;
      logic       fin_en;
      axis_type   fin_axis;
      logic       out_load;
      logic       out_nd;
      logic       walk_step;
      logic       walk_add;
      logic       walk_end;
      rd_sel_type rd_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_cmd;
      logic load_ends;
      logic loaded;
      logic need_div;
      logic out_free;
      logic last;
      logic walk_more;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ sv/cpar_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cpar_req_if;
   logic                               valid;
   logic                               ready;
   logic                               cmd;
   logic signed [cpar_pkg::COORD_W-1:0] vertex_x;
   logic signed [cpar_pkg::COORD_W-1:0] vertex_y;
   logic signed [cpar_pkg::COORD_W-1:0] vertex_z;
   logic [cpar_pkg::LEN_W-1:0]          edge_length;
   logic                               final_vertex;

   modport source (output valid, cmd, vertex_x, vertex_y, vertex_z, edge_length,
                   final_vertex, input ready);
   modport sink (input valid, cmd, vertex_x, vertex_y, vertex_z, edge_length,
                 final_vertex, output ready);
endinterface

interface cpar_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [cpar_pkg::COORD_W-1:0] point_x;
   logic signed [cpar_pkg::COORD_W-1:0] point_y;
   logic signed [cpar_pkg::COORD_W-1:0] point_z;
   logic                               last_point;
   logic                               no_data;

   modport source (output valid, point_x, point_y, point_z, last_point, no_data,
                   input ready);
   modport sink (input valid, point_x, point_y, point_z, last_point, no_data,
                 output ready);
endinterface

`default_nettype wire

@@ sv/cpar_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle while run is high. The dividend
// bits shift out of the quotient's top as quotient bits enter at the bottom.
module cpar_div (
   input  wire logic                             clock,
   input  wire logic                             load,
   input  wire logic                             run,
   input  wire logic [cpar_pkg::DIVREM_W-1:0]    rem_init,
   input  wire logic [cpar_pkg::PERIM_W-1:0]     quo_init,
   input  wire logic [cpar_pkg::LEN_W-1:0]       divisor,
   output logic      [cpar_pkg::PERIM_W-1:0]     quotient
);

   logic [cpar_pkg::DIVREM_W-1:0] rem_ff, rem_in;
   logic [cpar_pkg::PERIM_W-1:0]  quo_ff, quo_in;
   logic [cpar_pkg::LEN_W-1:0]    dvs_ff;
   logic [cpar_pkg::DIVREM_W-1:0] trial;
   logic                          ge;

   always_comb begin
      trial  = {rem_ff[cpar_pkg::DIVREM_W-2:0], quo_ff[cpar_pkg::PERIM_W-1]};
      ge     = trial >= {1'b0, dvs_ff};
      rem_in = ge ? (trial - {1'b0, dvs_ff}) : trial;
      quo_in = {quo_ff[cpar_pkg::PERIM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= rem_init;
         quo_ff <= quo_init;
         dvs_ff <= divisor;
      end else if (run) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ sv/cpar_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cpar_datapath #(
   parameter int MAX_VERTICES = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire cpar_pkg::ctrl_cmd_type               cmd,
   output cpar_pkg::dp_stat_type                     stat,
   input  wire logic                                 req_cmd,
   input  wire logic [cpar_pkg::COORD_W-1:0]         req_vertex_x,
   input  wire logic [cpar_pkg::COORD_W-1:0]         req_vertex_y,
   input  wire logic [cpar_pkg::COORD_W-1:0]         req_vertex_z,
   input  wire logic [cpar_pkg::LEN_W-1:0]           req_edge_length,
   input  wire logic                                 req_final_vertex,
   input  wire logic                                 csr_write_enable,
   input  wire logic [cpar_pkg::COUNT_W-1:0]         csr_write_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [cpar_pkg::COORD_W-1:0]              rsp_point_x,
   output logic [cpar_pkg::COORD_W-1:0]              rsp_point_y,
   output logic [cpar_pkg::COORD_W-1:0]              rsp_point_z,
   output logic                                      rsp_last_point,
   output logic                                      rsp_no_data
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int TW = $clog2(MAX_VERTICES + 1);
   localparam int CW = cpar_pkg::COORD_W;
   localparam int LW = cpar_pkg::LEN_W;
   localparam int PW = cpar_pkg::PERIM_W;
   localparam int RW = cpar_pkg::REM_W;
   localparam int NW = cpar_pkg::COUNT_W;

   cpar_pkg::vtx_entry_type mem [MAX_VERTICES];
   cpar_pkg::vtx_entry_type rdata_ff;

   logic [TW-1:0]   total_ff;
   logic [PW-1:0]   perim_ff;
   logic [PW-1:0]   step_ff;
   logic [AW-1:0]   cv_ff;
   logic [LW-1:0]   seg_ff;
   logic [RW-1:0]   rem_ff;
   logic [NW-1:0]   emitted_ff;
   logic            loaded_ff;
   logic [TW:0]     guard_ff;
   logic [NW-1:0]   pc_ff;
   logic [cpar_pkg::RATIO_W-1:0] r_ff;
   logic [CW-1:0]   vx_ff, vy_ff, vz_ff, nx_ff, ny_ff, nz_ff;
   logic [2*CW-1:0] prod_ff;
   logic [CW-1:0]   px_ff, py_ff, pz_ff;
   logic            out_valid_ff;
   logic [CW-1:0]   out_x_ff, out_y_ff, out_z_ff;
   logic            out_last_ff, out_nd_ff;

   logic [TW-1:0]   base_total, new_total;
   logic            wr_ok;
   logic [PW-1:0]   new_perim;
   logic [NW-1:0]   count;
   logic [AW-1:0]   next_v, rd_addr;
   logic            rem_pos;
   logic [PW-1:0]   quotient;
   logic [CW-1:0]   ma, mb, fa, fb, point;
   logic [CW:0]     md, mmag, fd, fmag, off;

   // Loading: a load after a finished polyline starts over at vertex 0.
   always_comb begin
      base_total = loaded_ff ? '0 : total_ff;
      wr_ok      = base_total < TW'(MAX_VERTICES);
      new_total  = base_total + TW'(wr_ok);
      new_perim  = (loaded_ff ? '0 : perim_ff)
                   + (wr_ok ? PW'(req_edge_length) : '0);
      count      = (pc_ff == '0) ? NW'(1) : pc_ff;
      next_v     = ((TW+1)'(cv_ff) + (TW+1)'(1) >= (TW+1)'(total_ff))
                   ? '0 : AW'(cv_ff + AW'(1));
      rem_pos    = !rem_ff[RW-1] && (rem_ff != '0);
   end

   always_comb begin
      unique case (cmd.rd_sel)
         cpar_pkg::RD_CUR:  rd_addr = cv_ff;
         cpar_pkg::RD_NEXT: rd_addr = next_v;
         cpar_pkg::RD_ZERO: rd_addr = '0;
         default:           rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load && wr_ok) begin
         mem[base_total[AW-1:0]] <= '{x: req_vertex_x, y: req_vertex_y,
                                      z: req_vertex_z, len: req_edge_length};
      end
      rdata_ff <= mem[rd_addr];
   end

   cpar_div u_div (
      .clock    (clock),
      .load     (cmd.step_go | cmd.ratio_go),
      .run      (cmd.div_run),
      .rem_init (cmd.step_go ? '0 : {1'b0, rem_ff[LW-1:0]}),
      .quo_init (cmd.step_go ? perim_ff : '0),
      .divisor  (cmd.step_go ? LW'(count) : seg_ff),
      .quotient (quotient)
   );

   // Interpolation operands for the multiply and finishing steps.
   always_comb begin
      unique case (cmd.mul_axis)
         cpar_pkg::AXIS_X: begin ma = vx_ff; mb = nx_ff; end
         cpar_pkg::AXIS_Y: begin ma = vy_ff; mb = ny_ff; end
         cpar_pkg::AXIS_Z: begin ma = vz_ff; mb = nz_ff; end
         default:          begin ma = vx_ff; mb = nx_ff; end
      endcase
      unique case (cmd.fin_axis)
         cpar_pkg::AXIS_X: begin fa = vx_ff; fb = nx_ff; end
         cpar_pkg::AXIS_Y: begin fa = vy_ff; fb = ny_ff; end
         cpar_pkg::AXIS_Z: begin fa = vz_ff; fb = nz_ff; end
         default:          begin fa = vx_ff; fb = nx_ff; end
      endcase
      md   = {mb[CW-1], mb} - {ma[CW-1], ma};
      mmag = md[CW] ? (~md + (CW+1)'(1)) : md;
      fd   = {fb[CW-1], fb} - {fa[CW-1], fa};
      fmag = fd[CW] ? (~fd + (CW+1)'(1)) : fd;
      // A full ratio gives the whole distance; a magnitude of exactly 2^32
      // has a zero low word, so the offset is then the ratio itself.
      if (r_ff[CW]) begin
         off = fmag;
      end else if (fmag[CW]) begin
         off = {1'b0, r_ff[CW-1:0]};
      end else begin
         off = {1'b0, prod_ff[2*CW-1:CW]};
      end
      point = fd[CW] ? (fb + off[CW-1:0]) : (fb - off[CW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.lat_v) begin
         vx_ff <= rdata_ff.x;
         vy_ff <= rdata_ff.y;
         vz_ff <= rdata_ff.z;
      end
      if (cmd.lat_n) begin
         nx_ff <= rdata_ff.x;
         ny_ff <= rdata_ff.y;
         nz_ff <= rdata_ff.z;
      end
      if (cmd.mul_en) begin
         prod_ff <= mmag[CW-1:0] * r_ff[CW-1:0];
      end
      if (cmd.fin_en) begin
         unique case (cmd.fin_axis)
            cpar_pkg::AXIS_X: px_ff <= point;
            cpar_pkg::AXIS_Y: py_ff <= point;
            cpar_pkg::AXIS_Z: pz_ff <= point;
            default:          px_ff <= point;
         endcase
      end
      if (cmd.ratio_set) begin
         r_ff <= (seg_ff != '0 && rem_pos && !stat.need_div)
                 ? {1'b1, {CW{1'b0}}} : '0;
      end else if (cmd.ratio_done) begin
         r_ff <= {1'b0, quotient[CW-1:0]};
      end
      if (cmd.step_done) begin
         step_ff <= quotient;
      end
      if (cmd.out_load) begin
         out_x_ff    <= cmd.out_nd ? '0 : px_ff;
         out_y_ff    <= cmd.out_nd ? '0 : py_ff;
         out_z_ff    <= cmd.out_nd ? '0 : pz_ff;
         out_last_ff <= !cmd.out_nd && stat.last;
         out_nd_ff   <= cmd.out_nd;
      end
   end

   // Walk state.
   always_ff @(posedge clock) begin
      if (cmd.restart) begin
         cv_ff      <= '0;
         seg_ff     <= rdata_ff.len;
         rem_ff     <= RW'(rdata_ff.len);
         emitted_ff <= '0;
      end else if (cmd.out_load && !cmd.out_nd && !stat.last) begin
         emitted_ff <= emitted_ff + NW'(1);
         rem_ff     <= rem_ff - RW'(step_ff);
         guard_ff   <= '0;
      end else if (cmd.walk_step) begin
         cv_ff <= next_v;
      end else if (cmd.walk_add) begin
         seg_ff   <= rdata_ff.len;
         rem_ff   <= rem_ff + RW'(rdata_ff.len);
         guard_ff <= guard_ff + (TW+1)'(1);
      end else if (cmd.walk_end && rem_ff[RW-1]) begin
         rem_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         perim_ff     <= '0;
         loaded_ff    <= 1'b0;
         pc_ff        <= cpar_pkg::POINT_COUNT_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            pc_ff <= csr_write_data;
         end
         if (cmd.load) begin
            total_ff  <= new_total;
            perim_ff  <= new_perim;
            loaded_ff <= 1'b0;
         end else if (cmd.restart) begin
            loaded_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      stat.req_cmd   = req_cmd;
      stat.load_ends = req_final_vertex && (new_total != '0);
      stat.loaded    = loaded_ff;
      stat.need_div  = (seg_ff != '0) && rem_pos && (rem_ff < RW'(seg_ff));
      stat.out_free  = !out_valid_ff || rsp_ready;
      stat.last      = ((NW+1)'(emitted_ff) + (NW+1)'(1)) >= (NW+1)'(count);
      stat.walk_more = rem_ff[RW-1] && (guard_ff <= (TW+1)'(total_ff));
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_point_x    = out_x_ff;
   assign rsp_point_y    = out_y_ff;
   assign rsp_point_z    = out_z_ff;
   assign rsp_last_point = out_last_ff;
   assign rsp_no_data    = out_nd_ff;

endmodule

`default_nettype wire

@@ sv/cpar_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cpar_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire cpar_pkg::dp_stat_type   stat,
   output cpar_pkg::ctrl_cmd_type       cmd
);

   localparam int IW = cpar_pkg::ITER_W;

   typedef enum logic [18:0] {
      S_IDLE    = 19'h00001,
      S_LOADFIN = 19'h00002,
      S_DSTEP   = 19'h00004,
      S_SDONE   = 19'h00008,
      S_RD0     = 19'h00010,
      S_RESTART = 19'h00020,
      S_RDV     = 19'h00040,
      S_RDN     = 19'h00080,
      S_GETN    = 19'h00100,
      S_DRAT    = 19'h00200,
      S_RDONE   = 19'h00400,
      S_MX      = 19'h00800,
      S_MY      = 19'h01000,
      S_MZ      = 19'h02000,
      S_MF      = 19'h04000,
      S_OUT     = 19'h08000,
      S_NDOUT   = 19'h10000,
      S_WALK    = 19'h20000,
      S_WALKADD = 19'h40000
   } state_type;

   state_type                      state_ff, state_in;
   logic [cpar_pkg::ITER_W-1:0]    cnt_ff, cnt_in;

   always_comb begin
      cmd       = '0;
      cmd.rd_sel   = cpar_pkg::RD_CUR;
      cmd.mul_axis = cpar_pkg::AXIS_X;
      cmd.fin_axis = cpar_pkg::AXIS_X;
      req_ready = 1'b0;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (stat.req_cmd == cpar_pkg::CMD_LOAD) begin
                  cmd.load = 1'b1;
                  state_in = stat.load_ends ? S_LOADFIN : S_IDLE;
               end else begin
                  state_in = stat.loaded ? S_RDV : S_NDOUT;
               end
            end
         end
         S_LOADFIN: begin
            cmd.step_go = 1'b1;
            cnt_in      = cpar_pkg::STEP_ITER_LAST;
            state_in    = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.div_run = 1'b1;
            cnt_in      = cnt_ff - IW'(1);
            if (cnt_ff == '0) begin
               state_in = S_SDONE;
            end
         end
         S_SDONE: begin
            cmd.step_done = 1'b1;
            cmd.rd_sel    = cpar_pkg::RD_ZERO;
            state_in      = S_RESTART;
         end
         S_RD0: begin
            cmd.rd_sel = cpar_pkg::RD_ZERO;
            state_in   = S_RESTART;
         end
         S_RESTART: begin
            cmd.restart = 1'b1;
            state_in    = S_IDLE;
         end
         S_RDV: begin
            cmd.rd_sel    = cpar_pkg::RD_CUR;
            cmd.ratio_set = 1'b1;
            state_in      = S_RDN;
         end
         S_RDN: begin
            cmd.lat_v  = 1'b1;
            cmd.rd_sel = cpar_pkg::RD_NEXT;
            state_in   = S_GETN;
         end
         S_GETN: begin
            cmd.lat_n = 1'b1;
            if (stat.need_div) begin
               cmd.ratio_go = 1'b1;
               cnt_in       = cpar_pkg::RATIO_ITER_LAST;
               state_in     = S_DRAT;
            end else begin
               state_in = S_MX;
            end
         end
         S_DRAT: begin
            cmd.div_run = 1'b1;
            cnt_in      = cnt_ff - IW'(1);
            if (cnt_ff == '0) begin
               state_in = S_RDONE;
            end
         end
         S_RDONE: begin
            cmd.ratio_done = 1'b1;
            state_in       = S_MX;
         end
         S_MX: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_axis = cpar_pkg::AXIS_X;
            state_in     = S_MY;
         end
         S_MY: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_axis = cpar_pkg::AXIS_Y;
            cmd.fin_en   = 1'b1;
            cmd.fin_axis = cpar_pkg::AXIS_X;
            state_in     = S_MZ;
         end
         S_MZ: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_axis = cpar_pkg::AXIS_Z;
            cmd.fin_en   = 1'b1;
            cmd.fin_axis = cpar_pkg::AXIS_Y;
            state_in     = S_MF;
         end
         S_MF: begin
            cmd.fin_en   = 1'b1;
            cmd.fin_axis = cpar_pkg::AXIS_Z;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = stat.last ? S_RD0 : S_WALK;
            end
         end
         S_NDOUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_nd   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_WALK: begin
            if (stat.walk_more) begin
               cmd.walk_step = 1'b1;
               cmd.rd_sel    = cpar_pkg::RD_NEXT;
               state_in      = S_WALKADD;
            end else begin
               cmd.walk_end = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_WALKADD: begin
            cmd.walk_add = 1'b1;
            state_in     = S_WALK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/closed_polyline_arc_resampler.sv @@
// A load word is written to the vertex store as it is taken; a final load word then has the
// step length divided out one quotient bit per cycle. An emit word runs the store reads, the
// ratio divide when it is needed, the multiply for each axis, a wait for the output register
// and the walk over vertices; with nothing loaded it gives only a no-data result. One word
// is worked on at a time; the output register lets a result wait.
// Reset (synchronous, active high) empties the polyline and sets the point count to 64.
`timescale 1ns / 1ps
`default_nettype none

module closed_polyline_arc_resampler #(
   parameter int MAX_VERTICES = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cpar_req_if.sink                           req_chan,
   cpar_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_write_enable,
   input  wire logic [cpar_pkg::COUNT_W-1:0]  csr_write_data
);

   // The controller sequences each word through the datapath: store reads,
   // the shared divider (step length at the end of a load, then the
   // interpolation ratio of a point when needed), the multiply for each axis and the
   // walk over edges once the remaining length has gone negative.
   cpar_pkg::ctrl_cmd_type cmd;
   cpar_pkg::dp_stat_type  stat;

   logic [cpar_pkg::COORD_W-1:0] point_x, point_y, point_z;

   cpar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the vertex store, the walk state, the point count
   // register and the output register that parts the result side from the
   // request side.
   cpar_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_cmd          (req_chan.cmd),
      .req_vertex_x     (req_chan.vertex_x),
      .req_vertex_y     (req_chan.vertex_y),
      .req_vertex_z     (req_chan.vertex_z),
      .req_edge_length  (req_chan.edge_length),
      .req_final_vertex (req_chan.final_vertex),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_point_x      (point_x),
      .rsp_point_y      (point_y),
      .rsp_point_z      (point_z),
      .rsp_last_point   (rsp_chan.last_point),
      .rsp_no_data      (rsp_chan.no_data)
   );

   assign rsp_chan.point_x = $signed(point_x);
   assign rsp_chan.point_y = $signed(point_y);
   assign rsp_chan.point_z = $signed(point_z);

   // An emit word moves the controller out of idle, so the request side
   // must close straight after it is taken.
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.cmd == cpar_pkg::CMD_EMIT)
      |=> !req_chan.ready)
      else $error("request side open in the cycle after an emit word");

   // A load word never produces a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.cmd == cpar_pkg::CMD_LOAD
       && !rsp_chan.valid) |=> !rsp_chan.valid)
      else $error("result word raised by a load word");

   // A no-data result carries a zero point and is never the last of a pass.
   a_nodata_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.no_data) |->
      (rsp_chan.point_x == '0 && rsp_chan.point_y == '0 && rsp_chan.point_z == '0
       && !rsp_chan.last_point))
      else $error("no-data result carries point data");

endmodule

`default_nettype wire
